// ----- hdl/priority_interval_counter_scheduler_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef PRIORITY_INTERVAL_COUNTER_SCHEDULER_MACROS_SVH
`define PRIORITY_INTERVAL_COUNTER_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PICS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
// Next-cycle implication, disabled during reset
`define PICS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define PICS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PICS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/pics_pkg.sv -----
// Types and constants for the priority interval counter scheduler.
// No dependencies; used by pics_step_unit and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pics_pkg;

    localparam int CNT_W  = 11;
    localparam int PRIO_W = 24;

    localparam logic [CNT_W-1:0]  CNT_MAX   = 11'h7FF;
    localparam logic [PRIO_W-1:0] PRIO_STEP = 24'd100;
    localparam logic [PRIO_W-1:0] PRIO_MAX  = 24'hFFFFFF;

    // Operation codes carried in the input tuser
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_ENABLE  = 3'd2;
    localparam logic [2:0] OP_RESET   = 3'd3;
    localparam logic [2:0] OP_HOLDOFF = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // One table entry as seen by the step unit
    typedef struct packed {
        logic [CNT_W-1:0]  tick;
        logic [CNT_W-1:0]  fires;
        logic [CNT_W-1:0]  interval;
        logic [CNT_W-1:0]  max_fires;
        logic [PRIO_W-1:0] prio;
        logic              enabled;
    } t_entry;

    // Arbitration context handed to the step unit
    typedef struct packed {
        logic              best_mode;
        logic              have_win;
        logic [PRIO_W-1:0] win_prio;
    } t_scan_ctl;

    // Step unit results
    typedef struct packed {
        logic [CNT_W-1:0]  tick_adv;
        logic              due;
        logic              take;
        logic [CNT_W-1:0]  tick_inc;
        logic [CNT_W-1:0]  fires_inc;
        logic              fire_cap;
        logic [PRIO_W-1:0] prio_bump;
    } t_step_res;

endpackage
`default_nettype wire

// ----- hdl/pics_step_unit.sv -----
// Shared evaluation unit: one table entry per cycle (advance, due test,
// priority compare) plus the firing arithmetic. Depends on pics_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pics_step_unit (
    input  wire pics_pkg::t_entry    i_entry,
    input  wire pics_pkg::t_scan_ctl i_ctl,
    output pics_pkg::t_step_res      o_res
);
    import pics_pkg::*;

    logic [CNT_W-1:0] w_tick_inc;
    logic [CNT_W-1:0] w_fires_inc;
    logic             w_better;

    // Saturating increments and priority compare
    assign w_tick_inc  = (i_entry.tick >= CNT_MAX) ? CNT_MAX : i_entry.tick + 11'd1;
    assign w_fires_inc = (i_entry.fires >= CNT_MAX) ? CNT_MAX : i_entry.fires + 11'd1;
    assign w_better    = !i_ctl.have_win || (i_entry.prio < i_ctl.win_prio);

    always_comb begin
        o_res.tick_inc  = w_tick_inc;
        o_res.fires_inc = w_fires_inc;
        o_res.fire_cap  = (i_entry.max_fires != '0) && (w_fires_inc >= i_entry.max_fires);
        o_res.prio_bump = (i_entry.prio > PRIO_MAX - PRIO_STEP) ? PRIO_MAX
                                                                : i_entry.prio + PRIO_STEP;
        if (i_ctl.best_mode) begin
            // Best mode: pick lowest priority, due is judged after the step
            o_res.tick_adv = i_entry.tick;
            o_res.due      = w_tick_inc >= i_entry.interval;
            o_res.take     = i_entry.enabled && w_better;
        end else begin
            // All mode: advance up to the interval, then test due
            o_res.tick_adv = (i_entry.tick < i_entry.interval) ? w_tick_inc : i_entry.tick;
            o_res.due      = o_res.tick_adv >= i_entry.interval;
            o_res.take     = i_entry.enabled && o_res.due && w_better;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/priority_interval_counter_scheduler.sv -----
// Priority interval counter scheduler: table of interval counters with
// one shared step unit walked by a sequencer. Depends on pics_pkg,
// pics_step_unit and the assertion macro header.
//
// Each input word is one operation. Load, enable, reset, hold-off, unused
// codes and ticks that are held off pass S_EXEC and S_EMIT to the result word.
// A tick not held off passes S_EXEC, S_SCAN over n = min(counters_in_use,
// COUNTERS, 8) entries, S_COMMIT and S_EMIT: the single step unit examines
// one table entry per cycle, then S_COMMIT applies the firing to the winner.
// s_axis_tready is high only while the sequencer is idle; one result word can
// wait in the output register while the next operation is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_interval_counter_scheduler_macros.svh"
module priority_interval_counter_scheduler #(
    parameter int COUNTERS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [3:0]  i_cfg_wdata,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] counter_index, [13:3] interval_ticks, [24:14] max_firings,
    // [40:25] start_priority, [41] enable_flag, [57:42] holdoff_ticks,
    // [58] holdoff_forever, [63:59] zero
    input  wire logic [63:0] s_axis_tdata,
    // [2:0] operation
    input  wire logic [2:0]  s_axis_tuser,
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] fired_index, [13:3] fired_total, [14] group_active, [15] zero
    output logic [15:0]      m_axis_tdata,
    // [0] fired
    output logic             m_axis_tuser
);
    import pics_pkg::*;

    localparam int ENTRIES = (COUNTERS < 8) ? COUNTERS : 8;
    localparam int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_COMMIT,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic       r_mode;
    logic [3:0] r_cnt;

    // Counter table
    logic [CNT_W-1:0]  r_tick  [ENTRIES];
    logic [CNT_W-1:0]  r_fires [ENTRIES];
    logic [CNT_W-1:0]  r_ivl   [ENTRIES];
    logic [CNT_W-1:0]  r_max   [ENTRIES];
    logic [PRIO_W-1:0] r_prio  [ENTRIES];
    logic [ENTRIES-1:0] r_en;

    // Group hold-off
    logic [15:0] r_hold;
    logic        r_goff;

    // Latched operation
    logic [2:0]       r_op;
    logic [2:0]       r_idx;
    logic [CNT_W-1:0] r_in_ivl;
    logic [CNT_W-1:0] r_in_max;
    logic [15:0]      r_in_prio;
    logic             r_in_en;
    logic [15:0]      r_in_hold;
    logic             r_in_forever;

    // Sequencer state
    logic [IDXW-1:0]   r_scan;
    logic [IDXW-1:0]   r_win;
    logic              r_have;
    logic [PRIO_W-1:0] r_wprio;
    logic              r_fired;
    logic [CNT_W-1:0]  r_total;

    // Output register
    logic             r_out_valid;
    logic             r_out_fired;
    logic [2:0]       r_out_idx;
    logic [CNT_W-1:0] r_out_total;
    logic             r_out_active;

    logic [3:0]      w_scan_n;
    logic [3:0]      w_scan_last;
    logic            w_idx_ok;
    logic [IDXW-1:0] w_wr_idx;
    logic [IDXW-1:0] w_rd_idx;
    logic            w_accept;
    t_entry          w_entry;
    t_scan_ctl       w_ctl;
    t_step_res       w_res;

    assign w_scan_n    = (r_cnt > 4'(ENTRIES)) ? 4'(ENTRIES) : r_cnt;
    assign w_scan_last = w_scan_n - 4'd1;
    assign w_idx_ok    = {1'b0, r_idx} < 4'(ENTRIES);
    assign w_wr_idx    = r_idx[IDXW-1:0];
    assign w_rd_idx    = (r_state == S_COMMIT) ? r_win : r_scan;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // Feed the shared step unit with the addressed entry
    always_comb begin
        w_entry.tick      = r_tick[w_rd_idx];
        w_entry.fires     = r_fires[w_rd_idx];
        w_entry.interval  = r_ivl[w_rd_idx];
        w_entry.max_fires = r_max[w_rd_idx];
        w_entry.prio      = r_prio[w_rd_idx];
        w_entry.enabled   = r_en[w_rd_idx];
        w_ctl.best_mode   = r_mode;
        w_ctl.have_win    = r_have;
        w_ctl.win_prio    = r_wprio;
    end

    pics_step_unit u_step (
        .i_entry (w_entry),
        .i_ctl   (w_ctl),
        .o_res   (w_res)
    );

    // Sequencer, table and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_cnt       <= 4'd8;
            r_hold      <= '0;
            r_goff      <= 1'b0;
            r_en        <= '0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_win       <= '0;
            r_have      <= 1'b0;
            r_fired     <= 1'b0;
            for (int k = 0; k < ENTRIES; k++) begin
                r_tick[k]  <= '0;
                r_fires[k] <= '0;
                r_ivl[k]   <= '0;
                r_max[k]   <= '0;
                r_prio[k]  <= '0;
            end
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE:  r_mode <= i_cfg_wdata[0];
                    CFG_COUNT: r_cnt  <= i_cfg_wdata;
                    default:   r_mode <= r_mode;
                endcase
            end

            // Drop the output word once taken, unless a new one replaces it
            if (m_axis_tvalid && m_axis_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= s_axis_tuser;
                        r_idx        <= s_axis_tdata[2:0];
                        r_in_ivl     <= s_axis_tdata[13:3];
                        r_in_max     <= s_axis_tdata[24:14];
                        r_in_prio    <= s_axis_tdata[40:25];
                        r_in_en      <= s_axis_tdata[41];
                        r_in_hold    <= s_axis_tdata[57:42];
                        r_in_forever <= s_axis_tdata[58];
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_have  <= 1'b0;
                    r_win   <= '0;
                    r_fired <= 1'b0;
                    r_total <= '0;
                    r_scan  <= '0;
                    case (r_op)
                        OP_TICK: begin
                            if (r_goff) begin
                                r_state <= S_EMIT;
                            end else if (r_hold != '0) begin
                                r_hold  <= r_hold - 16'd1;
                                r_state <= S_EMIT;
                            end else if (w_scan_n == 4'd0) begin
                                r_state <= S_COMMIT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        OP_LOAD: begin
                            if (w_idx_ok) begin
                                r_ivl[w_wr_idx]   <= r_in_ivl;
                                r_max[w_wr_idx]   <= r_in_max;
                                r_prio[w_wr_idx]  <= {8'd0, r_in_prio};
                                r_en[w_wr_idx]    <= r_in_en;
                                r_tick[w_wr_idx]  <= '0;
                                r_fires[w_wr_idx] <= '0;
                            end
                            r_state <= S_EMIT;
                        end
                        OP_ENABLE: begin
                            if (w_idx_ok) begin
                                r_en[w_wr_idx] <= r_in_en;
                            end
                            r_state <= S_EMIT;
                        end
                        OP_RESET: begin
                            if (w_idx_ok) begin
                                r_tick[w_wr_idx]  <= '0;
                                r_fires[w_wr_idx] <= '0;
                                r_en[w_wr_idx]    <= 1'b1;
                            end
                            r_state <= S_EMIT;
                        end
                        OP_HOLDOFF: begin
                            r_goff  <= r_in_forever;
                            r_hold  <= r_in_forever ? 16'd0 : r_in_hold;
                            r_state <= S_EMIT;
                        end
                        default: begin
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_SCAN: begin
                    // Advance in all mode, track the best candidate
                    if (!r_mode && r_en[r_scan]) begin
                        r_tick[r_scan] <= w_res.tick_adv;
                    end
                    if (w_res.take) begin
                        r_have  <= 1'b1;
                        r_win   <= r_scan;
                        r_wprio <= w_entry.prio;
                    end
                    if (4'(r_scan) == w_scan_last) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_scan <= r_scan + IDXW'(1);
                    end
                end
                S_COMMIT: begin
                    // Apply the firing to the winner; in best mode a winner not yet due only steps its tick
                    if (r_have) begin
                        if (r_mode && !w_res.due) begin
                            r_tick[r_win] <= w_res.tick_inc;
                        end else begin
                            r_tick[r_win] <= '0;
                            r_prio[r_win] <= w_res.prio_bump;
                            r_fired       <= 1'b1;
                            if (w_res.fire_cap) begin
                                r_en[r_win] <= 1'b0;
                            end
                            if (r_mode && w_res.fire_cap) begin
                                r_fires[r_win] <= w_entry.max_fires;
                                r_total        <= w_entry.max_fires;
                            end else begin
                                r_fires[r_win] <= w_res.fires_inc;
                                r_total        <= w_res.fires_inc;
                            end
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Hand the result to the output register when it is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_fired  <= r_fired;
                        r_out_idx    <= r_fired ? 3'(r_win) : 3'd0;
                        r_out_total  <= r_total;
                        r_out_active <= !r_goff && (r_hold == '0);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_fired;
    assign m_axis_tdata  = {1'b0, r_out_active, r_out_total, r_out_idx};

    `PICS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !s_axis_tready)
    `PICS_ASSERT_IMP(a_fire_total_nonzero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[13:3] != 11'd0)
    `PICS_ASSERT_IMP(a_nofire_clear, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[13:0] == 14'd0)
    `PICS_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, 4'(r_scan) <= w_scan_last)
    `PICS_ASSERT_IMP(a_winner_enabled, i_clk, i_rst_n, r_state == S_COMMIT && r_have, r_en[r_win])

endmodule
`default_nettype wire
